[rtl/saf_pkg.sv]
// Package for the swept box first-hit block: the queue entry type, the queue status
// group, the back end state encoding and the face normal codes.
// No dependencies.
`default_nettype none

package saf_pkg;

  // One classified obstacle transaction, as it waits in the queue.
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic        [30:0] hx;   // grown half width
    logic        [30:0] hy;   // grown half height
    logic signed [34:0] n1x;  // cx - hx - px
    logic signed [34:0] n2x;  // cx + hx - px
    logic signed [34:0] n1y;
    logic signed [34:0] n2y;
    logic               last;
    logic               reject; // a still axis does not start strictly inside its slab
  } saf_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } saf_qstat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROUTE,
    ST_SETUP,
    ST_DIV,
    ST_APPLY,
    ST_TEST,
    ST_MUL_X,
    ST_MUL_Y,
    ST_CONTACT,
    ST_FACE,
    ST_FINISH,
    ST_EMIT
  } saf_state_t;

  localparam logic [1:0] NORM_ZERO = 2'b00;
  localparam logic [1:0] NORM_POS  = 2'b01;
  localparam logic [1:0] NORM_NEG  = 2'b11;

endpackage

`default_nettype wire

[rtl/saf_front.sv]
// Front end of the swept box first-hit block: takes obstacle transactions, grows the
// obstacle, forms the slab numerators and flags early rejects. Uses saf_pkg.
`default_nettype none

module saf_front (
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [311:0]       s_tdata,
  input  wire logic               s_tlast,
  input  wire saf_pkg::saf_qstat_t qstat,
  output logic                    push,
  output saf_pkg::saf_item_t      item
);

  logic signed [31:0] px, py, dx, dy, cx, cy;
  logic        [29:0] mhw, mhh, ohw, ohh;
  logic        [30:0] hx, hy;
  logic signed [34:0] n1x, n2x, n1y, n2y;
  logic               in_x, in_y;

  assign px  = s_tdata[31:0];
  assign py  = s_tdata[63:32];
  assign mhw = s_tdata[93:64];
  assign mhh = s_tdata[123:94];
  assign dx  = s_tdata[155:124];
  assign dy  = s_tdata[187:156];
  assign cx  = s_tdata[219:188];
  assign cy  = s_tdata[251:220];
  assign ohw = s_tdata[281:252];
  assign ohh = s_tdata[311:282];

  assign hx = {1'b0, ohw} + {1'b0, mhw};
  assign hy = {1'b0, ohh} + {1'b0, mhh};

  assign n1x = 35'(cx) - $signed({4'b0, hx}) - 35'(px);
  assign n2x = 35'(cx) + $signed({4'b0, hx}) - 35'(px);
  assign n1y = 35'(cy) - $signed({4'b0, hy}) - 35'(py);
  assign n2y = 35'(cy) + $signed({4'b0, hy}) - 35'(py);

  // Strictly inside the slab: c - h < p < c + h.
  assign in_x = n1x[34] && !n2x[34] && (n2x != '0);
  assign in_y = n1y[34] && !n2y[34] && (n2y != '0);

  assign s_tready = !rst && !qstat.full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    item.px     = px;
    item.py     = py;
    item.dx     = dx;
    item.dy     = dy;
    item.cx     = cx;
    item.cy     = cy;
    item.hx     = hx;
    item.hy     = hy;
    item.n1x    = n1x;
    item.n2x    = n2x;
    item.n1y    = n1y;
    item.n2y    = n2y;
    item.last   = s_tlast;
    item.reject = ((dx == '0) && !in_x) || ((dy == '0) && !in_y);
  end

endmodule

`default_nettype wire

[rtl/saf_queue.sv]
// Two-entry queue between the front and back ends of the swept box first-hit block.
// Uses saf_pkg for the entry and status types.
`default_nettype none

module saf_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire saf_pkg::saf_item_t wr_item,
  input  wire logic               pop,
  output saf_pkg::saf_item_t      rd_item,
  output saf_pkg::saf_qstat_t     qstat
);

  saf_pkg::saf_item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_item;
  end

  assign rd_item     = slots[rd_ptr];
  assign qstat.full  = count[1];
  assign qstat.empty = (count == 2'd0);

endmodule

`default_nettype wire

[rtl/saf_back.sv]
// Back end of the swept box first-hit block: iterative slab divisions, contact and
// face normal, the kept earliest hit and the result register. Uses saf_pkg.
`default_nettype none

module saf_back #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire saf_pkg::saf_qstat_t        qstat,
  input  wire saf_pkg::saf_item_t         q_item,
  output logic                            pop,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic                            hit_found,
  output logic signed [FRAC_BITS+1:0]     hit_time,
  output logic signed [31:0]              contact_x,
  output logic signed [31:0]              contact_y,
  output logic signed [1:0]               face_normal_x,
  output logic signed [1:0]               face_normal_y
);

  localparam int TW    = FRAC_BITS + 2;
  localparam int PW    = 32 + TW;
  localparam int CNT_W = $clog2(TW + 1);
  localparam logic signed [TW-1:0] T_ZERO = '0;
  localparam logic signed [TW-1:0] T_ONE = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic signed [TW-1:0] T_MAX = {2'b01, {FRAC_BITS{1'b1}}};
  localparam logic signed [TW-1:0] T_MIN = {2'b10, {FRAC_BITS{1'b0}}};
  localparam logic        [TW-1:0] Q_LIM = {2'b10, {FRAC_BITS{1'b0}}};

  saf_pkg::saf_state_t state, state_next;
  saf_pkg::saf_item_t  item;

  logic [1:0]           div_sel;
  logic [CNT_W-1:0]     cnt;
  logic [31:0]          rem;
  logic [31:0]          divisor;
  logic [TW-1:0]        nbits;
  logic [TW-1:0]        quo;
  logic                 ovf;
  logic                 neg;
  logic signed [TW-1:0] t_first, t_entry, t_exit;
  logic                 hit;
  logic signed [PW-1:0] prod;
  logic signed [31:0]   kx, ky;

  logic                 best_valid;
  logic signed [TW-1:0] best_time;
  logic signed [31:0]   best_kx, best_ky;
  logic [1:0]           best_nx, best_ny;

  logic                 out_load;

  // Divider set-up for the selected numerator.
  logic signed [34:0] cur_n;
  logic signed [31:0] cur_d;
  logic        [34:0] abs_n;
  logic        [31:0] abs_d;
  logic               ovf_now;

  always_comb begin
    case (div_sel)
      2'd0:    cur_n = item.n1x;
      2'd1:    cur_n = item.n2x;
      2'd2:    cur_n = item.n1y;
      default: cur_n = item.n2y;
    endcase
  end
  assign cur_d   = div_sel[1] ? item.dy : item.dx;
  assign abs_n   = cur_n[34] ? 35'(-cur_n) : 35'(cur_n);
  assign abs_d   = cur_d[31] ? 32'(-cur_d) : 32'(cur_d);
  assign ovf_now = abs_n >= {1'b0, abs_d, 2'b00};

  // One restoring step per cycle.
  logic [32:0] trial;
  logic        ge;
  logic [31:0] rem_step;
  assign trial    = {rem, nbits[TW-1]};
  assign ge       = trial >= {1'b0, divisor};
  assign rem_step = ge ? 32'(trial - {1'b0, divisor}) : trial[31:0];

  // Saturated signed quotient.
  logic signed [TW-1:0] t_new, t_lo, t_hi;
  always_comb begin
    if (!neg) begin
      t_new = (ovf || quo[TW-1]) ? T_MAX : $signed(quo);
    end else begin
      t_new = (ovf || (quo > Q_LIM)) ? T_MIN : $signed(TW'(-quo));
    end
  end
  assign t_lo = (t_first < t_new) ? t_first : t_new;
  assign t_hi = (t_first < t_new) ? t_new : t_first;

  // Contact: p + floor(d * entry / 2^F), saturated.
  logic signed [31:0] mul_a;
  logic signed [33:0] prod_sh;
  logic signed [31:0] cur_p;
  logic signed [34:0] csum;
  logic signed [31:0] csat;
  assign mul_a   = (state == saf_pkg::ST_MUL_X) ? item.dx : item.dy;
  assign prod_sh = 34'(prod >>> FRAC_BITS);
  assign cur_p   = (state == saf_pkg::ST_MUL_Y) ? item.px : item.py;
  assign csum    = 35'(prod_sh) + 35'(cur_p);
  always_comb begin
    if (csum > 35'sh07FFFFFFF)       csat = 32'sh7FFFFFFF;
    else if (csum < -35'sh080000000) csat = 32'sh80000000;
    else                             csat = csum[31:0];
  end

  // Face normal from the axis with the smaller overlap.
  logic signed [32:0] rx, ry;
  logic        [32:0] arx, ary;
  logic signed [33:0] ox, oy;
  logic [1:0]         sx, sy, nx, ny;
  assign rx  = 33'(kx) - 33'(item.cx);
  assign ry  = 33'(ky) - 33'(item.cy);
  assign arx = rx[32] ? 33'(-rx) : 33'(rx);
  assign ary = ry[32] ? 33'(-ry) : 33'(ry);
  assign ox  = $signed({3'b0, item.hx}) - $signed({1'b0, arx});
  assign oy  = $signed({3'b0, item.hy}) - $signed({1'b0, ary});
  assign sx  = rx[32] ? saf_pkg::NORM_NEG : ((rx != '0) ? saf_pkg::NORM_POS : saf_pkg::NORM_ZERO);
  assign sy  = ry[32] ? saf_pkg::NORM_NEG : ((ry != '0) ? saf_pkg::NORM_POS : saf_pkg::NORM_ZERO);
  assign nx  = (ox < oy) ? sx : saf_pkg::NORM_ZERO;
  assign ny  = (ox < oy) ? saf_pkg::NORM_ZERO : sy;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      saf_pkg::ST_IDLE:    if (!qstat.empty) state_next = saf_pkg::ST_ROUTE;
      saf_pkg::ST_ROUTE: begin
        if (item.reject)         state_next = saf_pkg::ST_FINISH;
        else if (item.dx != '0)  state_next = saf_pkg::ST_SETUP;
        else if (item.dy != '0)  state_next = saf_pkg::ST_SETUP;
        else                     state_next = saf_pkg::ST_TEST;
      end
      saf_pkg::ST_SETUP:   state_next = saf_pkg::ST_DIV;
      saf_pkg::ST_DIV:     if (cnt == CNT_W'(1)) state_next = saf_pkg::ST_APPLY;
      saf_pkg::ST_APPLY: begin
        if (!div_sel[0])                          state_next = saf_pkg::ST_SETUP;
        else if (!div_sel[1] && item.dy != '0)    state_next = saf_pkg::ST_SETUP;
        else                                      state_next = saf_pkg::ST_TEST;
      end
      saf_pkg::ST_TEST:    state_next = hit ? saf_pkg::ST_MUL_X : saf_pkg::ST_FINISH;
      saf_pkg::ST_MUL_X:   state_next = saf_pkg::ST_MUL_Y;
      saf_pkg::ST_MUL_Y:   state_next = saf_pkg::ST_CONTACT;
      saf_pkg::ST_CONTACT: state_next = saf_pkg::ST_FACE;
      saf_pkg::ST_FACE:    state_next = saf_pkg::ST_FINISH;
      saf_pkg::ST_FINISH:  state_next = item.last ? saf_pkg::ST_EMIT : saf_pkg::ST_IDLE;
      saf_pkg::ST_EMIT:    if (!m_tvalid || m_tready) state_next = saf_pkg::ST_IDLE;
      default:             state_next = saf_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    unique case (state)
      saf_pkg::ST_IDLE: pop      = !qstat.empty;
      saf_pkg::ST_EMIT: out_load = !m_tvalid || m_tready;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  assign hit = (t_exit > t_entry) && (t_exit > T_ZERO) && (t_entry < T_ONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= saf_pkg::ST_IDLE;
      best_valid <= 1'b0;
      best_time  <= T_ONE;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == saf_pkg::ST_FACE && t_entry < best_time) begin
        best_valid <= 1'b1;
        best_time  <= t_entry;
      end else if (out_load) begin
        best_valid <= 1'b0;
        best_time  <= T_ONE;
      end
      if (out_load)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) item <= q_item;
    case (state)
      saf_pkg::ST_ROUTE: begin
        t_entry <= T_MIN;
        t_exit  <= T_MAX;
        div_sel <= (item.dx != '0) ? 2'd0 : 2'd2;
      end
      saf_pkg::ST_SETUP: begin
        rem     <= abs_n[33:2];
        divisor <= abs_d;
        nbits   <= {abs_n[1:0], {FRAC_BITS{1'b0}}};
        ovf     <= ovf_now;
        neg     <= cur_n[34] ^ cur_d[31];
        cnt     <= CNT_W'(TW);
      end
      saf_pkg::ST_DIV: begin
        rem   <= rem_step;
        nbits <= {nbits[TW-2:0], 1'b0};
        quo   <= {quo[TW-2:0], ge};
        cnt   <= cnt - CNT_W'(1);
      end
      saf_pkg::ST_APPLY: begin
        if (!div_sel[0]) begin
          t_first <= t_new;
          div_sel <= div_sel + 2'd1;
        end else begin
          if (t_lo > t_entry) t_entry <= t_lo;
          if (t_hi < t_exit)  t_exit  <= t_hi;
          div_sel <= 2'd2;
        end
      end
      saf_pkg::ST_MUL_X: prod <= PW'(mul_a * t_entry);
      saf_pkg::ST_MUL_Y: begin
        kx   <= csat;
        prod <= PW'(mul_a * t_entry);
      end
      saf_pkg::ST_CONTACT: ky <= csat;
      saf_pkg::ST_FACE: begin
        if (t_entry < best_time) begin
          best_kx <= kx;
          best_ky <= ky;
          best_nx <= nx;
          best_ny <= ny;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      hit_found     <= best_valid;
      hit_time      <= best_valid ? best_time : '0;
      contact_x     <= best_valid ? best_kx : '0;
      contact_y     <= best_valid ? best_ky : '0;
      face_normal_x <= best_valid ? best_nx : saf_pkg::NORM_ZERO;
      face_normal_y <= best_valid ? best_ny : saf_pkg::NORM_ZERO;
    end
  end

endmodule

`default_nettype wire

[rtl/swept_aabb_first_hit.sv]
// Top level of the swept box first-hit block: front end, queue and back end.
// Depends on saf_pkg, saf_front, saf_queue and saf_back.
//
//   Channel | Direction | Signals                     | Carries
//   s_      | in        | tvalid tready tdata tlast   | one obstacle per transaction
//   m_      | out       | tvalid tready tdata         | one result per query
//
// When both deltas are non-zero, an obstacle's time in the back end is set by
// the shared restoring divider that produces one quotient bit a cycle for each
// of the four slab times; a still axis skips its two divisions and a rejected
// obstacle goes straight to the finish state.
// The front end classifies in the cycle of acceptance and the two-entry queue
// lets it take two further obstacles while the back end works.
// A held result on m_ does not stop the back end until the next query ends.
// Reset is synchronous and active high and empties the queue and the result.
`default_nettype none

module swept_aabb_first_hit #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata, from bit 0: mover_center_x(32) mover_center_y(32) mover_half_w(30)
  // mover_half_h(30) move_dx(32) move_dy(32) obstacle_center_x(32)
  // obstacle_center_y(32) obstacle_half_w(30) obstacle_half_h(30)
  input  wire logic [311:0] s_tdata,
  input  wire logic         s_tlast,   // last_obstacle
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // m_tdata, from bit 0: hit_found(1) hit_time(FRAC_BITS+2) contact_x(32)
  // contact_y(32) face_normal_x(2) face_normal_y(2), zero padded to bytes
  output logic [((FRAC_BITS+71+7)/8)*8-1:0] m_tdata
);

  localparam int TW    = FRAC_BITS + 2;
  localparam int OUT_W = ((FRAC_BITS + 71 + 7) / 8) * 8;

  saf_pkg::saf_qstat_t qstat;
  saf_pkg::saf_item_t  wr_item, rd_item;
  logic                push, pop;

  logic                 hit_found;
  logic signed [TW-1:0] hit_time;
  logic signed [31:0]   contact_x, contact_y;
  logic signed [1:0]    face_normal_x, face_normal_y;

  saf_front u_front (
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .qstat    (qstat),
    .push     (push),
    .item     (wr_item)
  );

  saf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .qstat   (qstat)
  );

  saf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .qstat         (qstat),
    .q_item        (rd_item),
    .pop           (pop),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .hit_found     (hit_found),
    .hit_time      (hit_time),
    .contact_x     (contact_x),
    .contact_y     (contact_y),
    .face_normal_x (face_normal_x),
    .face_normal_y (face_normal_y)
  );

  assign m_tdata = OUT_W'({face_normal_y, face_normal_x, contact_y, contact_x,
                           hit_time, hit_found});

endmodule

`default_nettype wire

[rtl/saf_checker.sv]
// Port-level checks for the swept box first-hit block, bound to the top level.
// Depends on swept_aabb_first_hit.
`default_nettype none

module saf_checker #(
  parameter int FRAC_BITS = 16
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic [((FRAC_BITS+71+7)/8)*8-1:0] m_tdata
);

  localparam int TW = FRAC_BITS + 2;
  localparam int NX = TW + 65;
  localparam int NY = TW + 67;

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A miss carries all-zero fields.
  a_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[NY+1:1] == '0)
    else $error("miss result not zero");

  // A hit time is below one, at most one normal axis is set and no normal is 2'b10.
  a_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |->
      ($signed(m_tdata[TW:1]) < $signed({2'b01, {FRAC_BITS{1'b0}}}))
      && ((m_tdata[NX+1:NX] == 2'b00) || (m_tdata[NY+1:NY] == 2'b00))
      && (m_tdata[NX+1:NX] != 2'b10) && (m_tdata[NY+1:NY] != 2'b10))
    else $error("bad hit result");

  // Reset empties the result register.
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind swept_aabb_first_hit saf_checker #(.FRAC_BITS(FRAC_BITS)) u_saf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

[tb/saf_result_checker.sv]
`timescale 1ns / 100ps
// Result checker for the swept box first-hit block: watches both stream channels,
// predicts the earliest hit of every query and compares it with what the block sends.
// Depends on saf_pkg for the face normal codes.

module saf_result_checker #(
  parameter int FRAC_BITS = 16,
  parameter int RES_W = 88
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [311:0]     s_tdata,
  input  logic             s_tlast,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [RES_W-1:0] m_tdata,
  output int               failures,
  output int               outstanding,
  output int               hits_checked
);

  localparam longint ONE_T = longint'(1) << FRAC_BITS;
  localparam longint T_MIN = -2 * ONE_T;
  localparam longint T_MAX = 2 * ONE_T - 1;

  // Laid out as on m_tdata: hit_found in bit 0, face_normal_y at the top.
  typedef struct packed {
    logic [1:0]               ny;
    logic [1:0]               nx;
    logic [31:0]              ky;
    logic [31:0]              kx;
    logic [FRAC_BITS+1:0]     hit_t;
    logic                     found;
  } first_hit_t;

  first_hit_t hit_q[$];

  // Earliest hit of the query in progress.
  bit         best_valid;
  longint     best_t;
  longint     best_kx;
  longint     best_ky;
  logic [1:0] best_nx;
  logic [1:0] best_ny;

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [1:0] sign_code(longint v);
    if (v > 0) return saf_pkg::NORM_POS;
    if (v < 0) return saf_pkg::NORM_NEG;
    return saf_pkg::NORM_ZERO;
  endfunction

  // Clips the centre path against one grown slab; a still axis only passes when
  // the start lies strictly inside the slab.
  function automatic bit clip_axis(longint p, longint d, longint c, longint h,
                                   inout longint t_in, inout longint t_out);
    longint t1, t2;
    if (d == 0) return (p > c - h) && (p < c + h);
    t1 = clamp(((c - h - p) * ONE_T) / d, T_MIN, T_MAX);
    t2 = clamp(((c + h - p) * ONE_T) / d, T_MIN, T_MAX);
    if (t1 > t2) begin
      t_in  = (t2 > t_in) ? t2 : t_in;
      t_out = (t1 < t_out) ? t1 : t_out;
    end else begin
      t_in  = (t1 > t_in) ? t1 : t_in;
      t_out = (t2 < t_out) ? t2 : t_out;
    end
    return 1'b1;
  endfunction

  task automatic track_obstacle(input logic [311:0] d, input logic last);
    longint px, py, dx, dy, cx, cy, hx, hy, t_in, t_out, kx, ky, rx, ry, ox, oy;
    first_hit_t res;
    px = longint'(signed'(d[31:0]));
    py = longint'(signed'(d[63:32]));
    dx = longint'(signed'(d[155:124]));
    dy = longint'(signed'(d[187:156]));
    cx = longint'(signed'(d[219:188]));
    cy = longint'(signed'(d[251:220]));
    hx = longint'(d[281:252]) + longint'(d[93:64]);
    hy = longint'(d[311:282]) + longint'(d[123:94]);
    t_in = T_MIN;
    t_out = T_MAX;
    if (clip_axis(px, dx, cx, hx, t_in, t_out) && clip_axis(py, dy, cy, hy, t_in, t_out)
        && t_out > t_in && t_out > 0 && t_in < ONE_T) begin
      // Arithmetic right shift of a signed value rounds towards minus infinity.
      kx = clamp(px + ((dx * t_in) >>> FRAC_BITS), -(longint'(1) << 31),
                 (longint'(1) << 31) - 1);
      ky = clamp(py + ((dy * t_in) >>> FRAC_BITS), -(longint'(1) << 31),
                 (longint'(1) << 31) - 1);
      rx = kx - cx;
      ry = ky - cy;
      ox = hx - (rx < 0 ? -rx : rx);
      oy = hy - (ry < 0 ? -ry : ry);
      if (t_in < best_t) begin
        best_valid = 1'b1;
        best_t = t_in;
        best_kx = kx;
        best_ky = ky;
        best_nx = (ox < oy) ? sign_code(rx) : saf_pkg::NORM_ZERO;
        best_ny = (ox < oy) ? saf_pkg::NORM_ZERO : sign_code(ry);
      end
    end
    if (last) begin
      res = '0;
      if (best_valid) begin
        res.found = 1'b1;
        res.hit_t = best_t[FRAC_BITS+1:0];
        res.kx = best_kx[31:0];
        res.ky = best_ky[31:0];
        res.nx = best_nx;
        res.ny = best_ny;
      end
      hit_q.push_back(res);
      clear_best();
    end
  endtask

  task automatic clear_best();
    best_valid = 1'b0;
    best_t = ONE_T;
    best_kx = 0;
    best_ky = 0;
    best_nx = saf_pkg::NORM_ZERO;
    best_ny = saf_pkg::NORM_ZERO;
  endtask

  always @(posedge clk) begin
    first_hit_t got, want;
    if (rst) begin
      hit_q.delete();
      clear_best();
      failures <= 0;
      hits_checked <= 0;
      outstanding <= 0;
    end else begin
      if (s_tvalid && s_tready) track_obstacle(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(first_hit_t)-1:0];
        hits_checked <= hits_checked + 1;
        if (hit_q.size() == 0) begin
          if (failures < 10) $display("[%0t] unexpected result %h", $realtime, got);
          failures <= failures + 1;
        end else begin
          want = hit_q.pop_front();
          if (got.found !== want.found || got.hit_t !== want.hit_t || got.kx !== want.kx
              || got.ky !== want.ky || got.nx !== want.nx || got.ny !== want.ny) begin
            if (failures < 10)
              $display({"[%0t] mismatch: found %0b/%0b time %h/%h contact_x %h/%h ",
                        "contact_y %h/%h normal %h,%h/%h,%h (expected/actual)"},
                       $realtime, want.found, got.found, want.hit_t, got.hit_t,
                       want.kx, got.kx, want.ky, got.ky, want.nx, want.ny, got.nx, got.ny);
            failures <= failures + 1;
          end
        end
      end
      outstanding <= hit_q.size();
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Top of the testbench for the swept box first-hit block: clock, reset, obstacle
// stimulus and receiver back-pressure. Depends on saf_result_checker and the RTL.

module testbench;

  localparam int FRAC_BITS = 16;
  localparam int RES_W = ((FRAC_BITS + 71 + 7) / 8) * 8;
  localparam int RANDOM_OBSTACLES = 500;
  localparam int CYCLE_LIMIT = 1000000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [311:0]     s_tdata = '0;
  logic             s_tlast = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [RES_W-1:0] m_tdata;

  int failures, outstanding, hits_checked;
  int cycles = 0;
  int obstacles_sent = 0;
  int queries_sent = 0;
  // Idle percentages of the current phase for the sender and the receiver.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #2 clk = ~clk;

  swept_aabb_first_hit #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  saf_result_checker #(.FRAC_BITS(FRAC_BITS), .RES_W(RES_W)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .failures(failures), .outstanding(outstanding), .hits_checked(hits_checked)
  );

  // A watchdog: a healthy run finishes far inside this budget.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycles, outstanding);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The receiver stalls at random according to the current phase.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Sends one obstacle transaction. Inputs change only at the falling edge; tready is
  // looked at a quarter period later, when it has settled, and the transfer takes place
  // at the following rising edge. tvalid stays high between back-to-back transactions.
  task automatic send_obstacle(input logic [31:0] px, py, input logic [29:0] mhw, mhh,
                               input logic [31:0] dx, dy, cx, cy,
                               input logic [29:0] ohw, ohh, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {ohh, ohw, cy, cx, dy, dx, mhh, mhw, py, px};
    s_tlast = last;
    #1;
    while (!s_tready) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
    obstacles_sent++;
    if (last) queries_sent++;
  endtask

  // An obstacle with every bit of every field at random: mostly misses.
  task automatic send_noise(input logic last);
    send_obstacle($urandom, $urandom, 30'($urandom), 30'($urandom), $urandom, $urandom,
                  $urandom, $urandom, 30'($urandom), 30'($urandom), last);
  endtask

  // An obstacle placed somewhere along or near the mover's path, so that the slab test
  // usually gets as far as the entry time and the face choice.
  task automatic send_on_path(input int px, py, dx, dy, input logic [29:0] mhw, mhh,
                              input logic last);
    int along, cx, cy;
    along = $urandom_range(1200) - 100;
    cx = px + int'((longint'(dx) * along) / 1000) + $signed($urandom_range(8192)) - 4096;
    cy = py + int'((longint'(dy) * along) / 1000) + $signed($urandom_range(8192)) - 4096;
    send_obstacle(px, py, mhw, mhh, dx, dy, cx, cy,
                  30'($urandom_range(1 << 20)), 30'($urandom_range(1 << 20)), last);
  endtask

  initial begin
    int px, py, dx, dy, len;
    logic [29:0] mhw, mhh;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part.
    // Both deltas zero with the start strictly inside: hit at -2.0.
    send_obstacle(32'h0001_0000, 32'h0002_0000, 30'h1_0000, 30'h1_0000, 0, 0,
                  32'h0001_8000, 32'h0002_0000, 30'h1_0000, 30'h1_0000, 1'b1);
    // Still x axis with the start outside the slab.
    send_obstacle(0, 0, 30'h1_0000, 30'h1_0000, 0, 32'h0010_0000,
                  32'h0005_0000, 32'h0004_0000, 30'h1_0000, 30'h1_0000, 1'b1);
    // Still x axis with the start exactly on the slab edge: rejected.
    send_obstacle(0, 0, 30'h1_0000, 30'h1_0000, 0, 32'h0010_0000,
                  32'h0002_0000, 32'h0004_0000, 30'h1_0000, 30'h1_0000, 1'b1);
    // Plain hits along +x and -y, then one query whose second obstacle is earlier than
    // its first and whose third has equal times, where the second must stay.
    send_obstacle(0, 0, 30'h8000, 30'h8000, 32'h000A_0000, 0,
                  32'h0005_0000, 32'h0000_4000, 30'h1_0000, 30'h1_0000, 1'b1);
    send_obstacle(0, 0, 30'h8000, 30'h8000, 0, 32'hFFF6_0000,
                  32'h0000_2000, 32'hFFFA_0000, 30'h1_0000, 30'h1_0000, 1'b1);
    send_obstacle(0, 0, 30'h8000, 30'h8000, 32'h000A_0000, 32'h0003_0000,
                  32'h0008_0000, 32'h0002_4000, 30'h1_0000, 30'h1_0000, 1'b0);
    send_obstacle(0, 0, 30'h8000, 30'h8000, 32'h000A_0000, 32'h0003_0000,
                  32'h0003_0000, 32'h0000_E000, 30'h1_0000, 30'h1_0000, 1'b0);
    send_obstacle(0, 0, 30'h8000, 30'h8000, 32'h000A_0000, 32'h0003_0000,
                  32'h0003_0000, 32'h0000_E000, 30'h1_0000, 30'h1_0000, 1'b1);
    // A tiny delta against a huge obstacle: the entry time saturates at -2.0.
    send_obstacle(0, 0, 30'h1_0000, 30'h1_0000, 32'h0000_0001, 0,
                  0, 0, 30'h3FFF_FFFF, 30'h1_0000, 1'b1);
    // Saturated entry far behind a start near the bottom: the contact saturates.
    send_obstacle(32'h8100_0000, 0, 30'h3FFF_FFFF, 30'h1_0000, 32'h4000_0000, 0,
                  32'h80FF_FFFE, 0, 30'h3FFF_FFFF, 30'h1_0000, 1'b1);
    // Field extremes.
    send_obstacle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 30'h3FFF_FFFF, 30'h3FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  30'h3FFF_FFFF, 30'h3FFF_FFFF, 1'b0);
    send_obstacle(32'h8000_0000, 32'h8000_0000, 30'd0, 30'd0, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h8000_0000, 30'd0, 30'd0, 1'b1);
    send_obstacle(32'h8000_0000, 32'h7FFF_FFFF, 30'h3FFF_FFFF, 30'd0, 32'h8000_0000, 0,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 1'b1);
    send_obstacle(0, 0, 30'd0, 30'd0, 0, 0, 0, 0, 30'd0, 30'd0, 1'b1);

    // Random part in four phases of back-pressure: none, sender idle, receiver
    // stalling, both.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 60 : (phase == 3) ? 14 : 0;
      recv_stall_pct = (phase == 2) ? 60 : (phase == 3) ? 14 : 0;
      while (obstacles_sent < 14 + (phase + 1) * RANDOM_OBSTACLES / 4) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(5, 1);
        px = $signed($urandom) >>> $urandom_range(12, 4);
        py = $signed($urandom) >>> $urandom_range(12, 4);
        dx = ($urandom_range(7) == 0) ? 0 : $signed($urandom) >>> $urandom_range(14, 6);
        dy = ($urandom_range(7) == 0) ? 0 : $signed($urandom) >>> $urandom_range(14, 6);
        mhw = 30'($urandom_range(1 << 19));
        mhh = 30'($urandom_range(1 << 19));
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(9) < 2) send_noise(k == len - 1);
          else send_on_path(px, py, dx, dy, mhw, mhh, k == len - 1);
        end
      end
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    s_tlast = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (outstanding != 0) @(posedge clk);
    // Let anything still in flight surface as an unexpected result.
    repeat (400) @(posedge clk);

    $display("%0d obstacles in %0d queries sent, %0d results checked over four phases",
             obstacles_sent, queries_sent, hits_checked);
    if (failures == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", failures, outstanding);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
